@@ design/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants for the sorted table search core
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int CFG_W       = 8;

  // register indexes on the configuration port
  localparam logic REG_ELEMENT_COUNT      = 1'b0;
  localparam logic REG_SORT_BEFORE_SEARCH = 1'b1;

  // item kinds
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [ADDR_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] element_count;
    logic               sort_before_search;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } result_t;

endpackage

@@ design/sts_ram.sv @@
// ----------------------------------------------------------------------------
// sts_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/sts_engine.sv @@
// ----------------------------------------------------------------------------
// sts_engine
// table memory with the load, bubble sort and binary search sequencer
// ----------------------------------------------------------------------------
module sts_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sts_pkg::item_t   item,
  input  sts_pkg::cfg_t    cfg,
  input  logic             slot_free,
  output logic             idle,
  output logic             res_push,
  output sts_pkg::result_t res
);
  import sts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD0,
    S_SORT_LOAD,
    S_SORT_SWEEP,
    S_SORT_END,
    S_SRCH_CHECK,
    S_SRCH_CMP,
    S_DONE
  } state_t;

  state_t                    state;
  logic signed [DATA_W-1:0]  key;
  logic signed [DATA_W-1:0]  carry;
  logic [ADDR_W-1:0]         k;
  logic [ADDR_W-1:0]         m;
  logic signed [ADDR_W+1:0]  low;
  logic signed [ADDR_W+1:0]  high;
  logic [ADDR_W-1:0]         mid;
  logic                      found;
  logic [ADDR_W-1:0]         position;

  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [DATA_W-1:0]         wdata;
  logic [ADDR_W-1:0]         raddr;
  logic [DATA_W-1:0]         rdata;
  logic signed [DATA_W-1:0]  rdata_s;
  logic [COUNT_W-1:0]        n_sat;
  logic [ADDR_W+2:0]         mid_sum;
  logic [ADDR_W-1:0]         mid_calc;

  sts_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rdata_s = $signed(rdata);
  assign n_sat   = (cfg.element_count > COUNT_W'(TABLE_DEPTH)) ?
                   COUNT_W'(TABLE_DEPTH) : cfg.element_count;
  // low and high are both non-negative whenever a probe is made
  assign mid_sum  = {low[ADDR_W+1], low} + {high[ADDR_W+1], high};
  assign mid_calc = mid_sum[ADDR_W:1];

  assign idle     = (state == S_IDLE);
  assign res_push = (state == S_DONE) && slot_free;
  assign res      = '{found: found, position: position};

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = item.index;
    wdata = item.value;
    raddr = '0;
    case (state)
      S_IDLE: begin
        we = start && (item.action == ACT_LOAD);
      end
      S_SORT_RD0: begin
        raddr = '0;
      end
      S_SORT_LOAD: begin
        raddr = ADDR_W'(1);
      end
      S_SORT_SWEEP: begin
        // fetch one ahead, write the smaller of the pair behind
        raddr = k + ADDR_W'(2);
        we    = 1'b1;
        waddr = k;
        wdata = (rdata_s < carry) ? rdata : carry;
      end
      S_SORT_END: begin
        we    = 1'b1;
        waddr = m;
        wdata = carry;
      end
      S_SRCH_CHECK: begin
        raddr = mid_calc;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && (item.action == ACT_SEARCH)) begin
            key <= item.value;
            low <= '0;
            high <= $signed({2'b00, n_sat[ADDR_W-1:0]}) + $signed({1'b0, n_sat[ADDR_W]})
                    * $signed((ADDR_W+2)'(TABLE_DEPTH)) - (ADDR_W+2)'(1);
            m   <= ADDR_W'(n_sat - COUNT_W'(1));
            if (cfg.sort_before_search && (n_sat > COUNT_W'(1))) begin
              state <= S_SORT_RD0;
            end else begin
              state <= S_SRCH_CHECK;
            end
          end
        end
        S_SORT_RD0: begin
          state <= S_SORT_LOAD;
        end
        S_SORT_LOAD: begin
          carry <= rdata_s;
          k     <= '0;
          state <= S_SORT_SWEEP;
        end
        S_SORT_SWEEP: begin
          if (!(rdata_s < carry)) begin
            carry <= rdata_s;
          end
          if ((k + ADDR_W'(1)) == m) begin
            state <= S_SORT_END;
          end else begin
            k <= k + ADDR_W'(1);
          end
        end
        S_SORT_END: begin
          if (m == ADDR_W'(1)) begin
            state <= S_SRCH_CHECK;
          end else begin
            m     <= m - ADDR_W'(1);
            state <= S_SORT_RD0;
          end
        end
        S_SRCH_CHECK: begin
          if (low > high) begin
            found    <= 1'b0;
            position <= '0;
            state    <= S_DONE;
          end else begin
            mid   <= mid_calc;
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (rdata_s == key) begin
            found    <= 1'b1;
            position <= mid;
            state    <= S_DONE;
          end else begin
            if (rdata_s < key) begin
              low <= $signed({2'b00, mid}) + (ADDR_W+2)'(1);
            end else begin
              high <= $signed({2'b00, mid}) - (ADDR_W+2)'(1);
            end
            state <= S_SRCH_CHECK;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/sorted_table_binary_search_core.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// table of signed 32-bit entries with in-place bubble sort and binary search
// ----------------------------------------------------------------------------
// usage:
//   input items arrive on the s_axis channel; tuser carries the kind of item
//   (0 load, 1 search). a load writes value into the table at index and gives
//   no result. a search gives exactly one result item on m_axis: tuser is the
//   found flag, tdata the position (0 on a miss).
//   the configuration port writes element_count (index 0) and sort_before_search
//   (index 1); the user must write only while the core is idle; it is not enforced.
// search and sort:
//   a load is written into the table as it is accepted. a search reads one
//   probe at a time through the single read port, and a miss ends with a
//   final bounds check after the last probe.
//   with sorting, bubble passes over m+1 entries, for m from n-1 down to 1,
//   run first, limited by the one read and one write port.
// reset:
//   rst clears both registers to 0 and drops m_axis_tvalid; table contents
//   stay undefined until loaded.
// stall:
//   a finished result waits in the output register while the next item is
//   accepted; a later search holds its result until that register is free.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]   cfg_wdata,
  // input items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,  // index[6:0], value[38:7], zero pad
  input  logic                        s_axis_tuser,  // action[0]
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // position[6:0], zero pad
  output logic                        m_axis_tuser   // found[0]
);
  import sts_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  result_t out_res;
  logic    start;
  logic    idle;
  logic    res_push;
  logic    slot_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ELEMENT_COUNT:      cfg.element_count      <= cfg_wdata[COUNT_W-1:0];
        REG_SORT_BEFORE_SEARCH: cfg.sort_before_search <= cfg_wdata[0];
        default:                cfg                    <= cfg;
      endcase
    end
  end

  // unpack the incoming item
  assign item.action = s_axis_tuser;
  assign item.index  = s_axis_tdata[ADDR_W-1:0];
  assign item.value  = $signed(s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]);

  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  // result register is free when empty or being drained this cycle
  assign slot_free     = !m_axis_tvalid || m_axis_tready;

  sts_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg       (cfg),
    .slot_free (slot_free),
    .idle      (idle),
    .res_push  (res_push),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.position};
  assign m_axis_tuser = out_res.found;

endmodule

@@ design/sts_checker.sv @@
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks on the sorted table search core
// ----------------------------------------------------------------------------
module sts_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);
  import sts_pkg::*;

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a miss always reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("miss with non-zero position");

  // a search keeps the input side busy on the following cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_SEARCH) |=> !s_axis_tready)
    else $error("input ready right after a search item");

endmodule

bind sorted_table_binary_search_core sts_checker u_sts_checker (.*);
